/* src/tfms_pkg.sv */
// Shared types, codes and defaults for the tolerance-filtered minimum stress search.
// No dependencies; imported by every module of the block.
package tfms_pkg;

  localparam int TFMS_DEPTH = 1024;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic CFG_E_TOL  = 1'b0;
  localparam logic CFG_NU_TOL = 1'b1;

  localparam logic [15:0] E_TOL_RESET  = 16'd13107;
  localparam logic [14:0] NU_TOL_RESET = 15'd819;

  typedef struct packed {
    logic [31:0] e;
    logic [15:0] nu;
    logic [31:0] stress;
  } entry_t;

  typedef struct packed {
    logic start;
    logic valid;
  } eval_ctl_t;

  typedef struct packed {
    logic busy;
    logic found;
  } eval_stat_t;

endpackage

/* src/tolerance_filtered_min_stress_search_core.sv */
// Top level of the tolerance-filtered minimum stress search: sequencer, registers, result stage.
// Depends on tfms_pkg, tfms_store and tfms_eval.
//
// Usage. Requests arrive on the in_valid/in_ready channel with func, value_e, value_nu
// and stress; each request produces exactly one result on the out_valid/out_ready
// channel carrying status, best_index, best_stress and entry_count.
// A clear, an append or an unused code passes through accept, execute, result staging
// and the output register before its result is presented. A query scans the held
// entries one per cycle through a single evaluation unit fed from the registered read
// port of the entry memory; a zero target skips the scan. Between the read pointer and
// the running minimum lie the memory read register and the two stages of the
// evaluation unit. With a receiver that keeps up, the next request is taken as soon
// as the sequencer has returned to idle from the result stage of the previous one.
// The block holds one request at a time: in_ready is high only while the sequencer
// is idle. A result waiting in the output register does not block the next request;
// if the receiver stalls, the finished result of that next request is kept in the
// staging registers until the output register is free.
// Reset (synchronous, active high) empties the table and restores the default
// tolerances of 0.20 relative stiffness and 0.05 Poisson ratio. The entry memory
// itself is not cleared; only entries below the count are ever read. The user must write
// tolerances through cfg_we/cfg_index/cfg_data while the block is idle, which is not enforced.
module tolerance_filtered_min_stress_search_core import tfms_pkg::*; #(
  parameter int DEPTH = TFMS_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] value_e,
  input  logic [15:0] value_nu,
  input  logic [31:0] stress,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [9:0]  best_index,
  output logic [31:0] best_stress,
  output logic [10:0] entry_count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic [15:0]      e_tolerance;
  logic [14:0]      nu_tolerance;

  // Request held for the whole of its processing.
  logic [1:0]       req_func;
  logic [31:0]      req_e;
  logic [15:0]      req_nu;
  logic [31:0]      req_stress;
  logic [47:0]      lim;

  // Scan pointer and read pipeline.
  logic [CNT_W-1:0] rd_ptr;
  logic             p1_valid;
  logic [IDX_W-1:0] p1_idx;
  logic             issue;
  logic             scan_done;

  // Result staging.
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_index;
  logic [31:0]      res_stress;

  logic             store_we;
  entry_t           store_wdata;
  entry_t           store_rdata;
  eval_ctl_t        ev_ctl;
  eval_stat_t       ev_stat;
  logic [IDX_W-1:0] ev_best_idx;
  logic [31:0]      ev_best_stress;
  logic             out_free;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign issue     = (state == S_SCAN) && (rd_ptr < count);
  assign scan_done = (state == S_SCAN) && !issue && !p1_valid && !ev_stat.busy;

  // An append writes the slot at the current count, if there is room.
  assign store_we          = (state == S_EXEC) && (req_func == FN_APPEND)
                             && (count != CNT_W'(DEPTH));
  assign store_wdata.e      = req_e;
  assign store_wdata.nu     = req_nu;
  assign store_wdata.stress = req_stress;

  assign ev_ctl.start = (state == S_EXEC);
  assign ev_ctl.valid = p1_valid;

  tfms_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (store_wdata),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (store_rdata)
  );

  tfms_eval #(
    .IDX_W (IDX_W)
  ) u_eval (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ev_ctl),
    .entry       (store_rdata),
    .entry_idx   (p1_idx),
    .target_e    (req_e),
    .target_nu   (req_nu),
    .lim         (lim),
    .nu_tol      (nu_tolerance),
    .stat        (ev_stat),
    .best_idx    (ev_best_idx),
    .best_stress (ev_best_stress)
  );

  // Tolerance registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_tolerance  <= E_TOL_RESET;
      nu_tolerance <= NU_TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_E_TOL:  e_tolerance  <= cfg_data;
        CFG_NU_TOL: nu_tolerance <= cfg_data[14:0];
        default:    ;
      endcase
    end
  end

  // Sequencer and table count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req_func == FN_QUERY && req_e != 32'd0) begin
            state <= S_SCAN;
          end else begin
            state <= S_RESULT;
          end
          if (req_func == FN_CLEAR) begin
            count <= '0;
          end else if (store_we) begin
            count <= count + 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: request capture, product limit, scan pointer, staging.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_func   <= func;
      req_e      <= value_e;
      req_nu     <= value_nu;
      req_stress <= stress;
    end
    if (issue) begin
      rd_ptr <= rd_ptr + 1'b1;
      p1_idx <= rd_ptr[IDX_W-1:0];
    end
    if (state == S_EXEC) begin
      // The relative test compares |E - T| * 2^16 against e_tolerance * T.
      lim        <= 48'(e_tolerance) * 48'(req_e);
      rd_ptr     <= '0;
      res_stress <= 32'd0;
      // A refused append reports a full table; a zero target cannot define a
      // relative error, so that query reports no match without scanning.
      if (req_func == FN_APPEND && count == CNT_W'(DEPTH)) begin
        res_status <= ST_FULL;
      end else if (req_func == FN_QUERY && req_e == 32'd0) begin
        res_status <= ST_NONE;
      end else begin
        res_status <= ST_OK;
      end
      if (store_we) begin
        res_index <= count[IDX_W-1:0];
      end else begin
        res_index <= '0;
      end
    end
    if (scan_done) begin
      if (ev_stat.found) begin
        res_status <= ST_OK;
        res_index  <= ev_best_idx;
        res_stress <= ev_best_stress;
      end else begin
        res_status <= ST_NONE;
      end
    end
  end

  // Output register; it is refilled in the same cycle in which it is taken, if a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == S_RESULT && out_free) begin
      status      <= res_status;
      best_index  <= 10'(res_index);
      best_stress <= res_stress;
      entry_count <= 11'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == 11'(DEPTH))
    else $error("table full reported with room left");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NONE |-> best_index == 10'd0 && best_stress == 32'd0)
    else $error("not-found result carries an entry");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !p1_valid && !ev_stat.busy)
    else $error("scan pipeline active while idle");
`endif

endmodule

/* src/tfms_store.sv */
// Entry table: one write port, one read port with registered read data.
// Depends on tfms_pkg for the entry layout.
module tfms_store import tfms_pkg::*; #(
  parameter int DEPTH = TFMS_DEPTH,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tfms_eval.sv */
// Shared evaluation unit: tolerance test of one entry per cycle and running minimum.
// Depends on tfms_pkg for the entry layout and the control structs.
module tfms_eval import tfms_pkg::*; #(
  parameter int IDX_W = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  eval_ctl_t          ctl,
  input  entry_t             entry,
  input  logic [IDX_W-1:0]   entry_idx,
  input  logic [31:0]        target_e,
  input  logic [15:0]        target_nu,
  input  logic [47:0]        lim,
  input  logic [14:0]        nu_tol,
  output eval_stat_t         stat,
  output logic [IDX_W-1:0]   best_idx,
  output logic [31:0]        best_stress
);

  logic             a_valid;
  logic [31:0]      a_de;
  logic [15:0]      a_adn;
  logic [IDX_W-1:0] a_idx;
  logic [31:0]      a_stress;
  logic             found;

  logic signed [16:0] dn;
  logic [16:0]        dn_abs;
  logic               qual;

  // Stage A: absolute differences.
  always_comb begin
    dn     = $signed({entry.nu[15], entry.nu}) - $signed({target_nu[15], target_nu});
    dn_abs = dn[16] ? 17'(-dn) : 17'(dn);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= ctl.valid;
    end
    a_de     <= (entry.e >= target_e) ? entry.e - target_e : target_e - entry.e;
    a_adn    <= dn_abs[15:0];
    a_idx    <= entry_idx;
    a_stress <= entry.stress;
  end

  // Stage B: both tolerance tests, then a strict less-than so the first equal entry stays.
  assign qual = ({a_de, 16'd0} <= lim) && (a_adn <= {1'b0, nu_tol});

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      found <= 1'b0;
    end else if (a_valid && qual && (!found || a_stress < best_stress)) begin
      found <= 1'b1;
    end
    if (!ctl.start && a_valid && qual && (!found || a_stress < best_stress)) begin
      best_idx    <= a_idx;
      best_stress <= a_stress;
    end
  end

  assign stat.busy  = a_valid;
  assign stat.found = found;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for tolerance_filtered_min_stress_search_core.
// Needs tfms_pkg and the block's RTL only. A predictor models the table and tolerances,
// and each result is compared with the oldest prediction while both sides stall at random.
module tb_top;
  import tfms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The fourth function code is not used by the block; such a request only reports the
  // current entry count.
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // The longest correct stretch without any handshake is a query over a full table or the
  // deliberate receiver hold-off. The limit is several times the longer of the two.
  localparam int STALL_LIMIT   = 6000;
  localparam int HOLD_CYCLES   = 240;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_CAP    = 200;
  localparam int LONG_TABLE    = 300;
  localparam logic [31:0] UNIT_E = 32'h0001_0000;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  best_index;
    logic [31:0] best_stress;
    logic [10:0] entry_count;
  } search_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FN_CLEAR;
  logic [31:0] value_e = '0;
  logic [15:0] value_nu = '0;
  logic [31:0] stress = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [9:0]  best_index;
  logic [31:0] best_stress;
  logic [10:0] entry_count;

  // Predictor state: the table contents, the number of held entries and both tolerances.
  entry_t      held_entries [TFMS_DEPTH];
  int          held_count = 0;
  logic [15:0] e_tol_model = E_TOL_RESET;
  logic [14:0] nu_tol_model = NU_TOL_RESET;

  search_result_t awaited_results [$];

  int errors = 0;
  int max_gap = 13;
  bit hold_sink = 1'b0;
  int idle_cycles = 0;
  int n_clear = 0, n_append = 0, n_query = 0, n_unused = 0;
  int n_hits = 0, n_misses = 0, n_full = 0, n_checked = 0;

  tolerance_filtered_min_stress_search_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .value_e    (value_e),
    .value_nu   (value_nu),
    .stress     (stress),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .best_index (best_index),
    .best_stress(best_stress),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor. Applies one accepted request to the model state and returns the result the
  // block must produce for it. The relative stiffness test is done by cross-multiplication:
  // an entry qualifies when |E - T| * 2^16 <= e_tolerance * T and |nu - R| <= nu_tolerance.
  // The lowest stress wins; on equal stress the entry seen first (lowest index) is kept.
  // ---------------------------------------------------------------------------------------
  function automatic search_result_t search_outcome(logic [1:0] fn, logic [31:0] e,
                                                    logic [15:0] nu, logic [31:0] st);
    search_result_t   r;
    longint unsigned  tol64, tgt64, limit, e_gap;
    shortint          target_nu, entry_nu;
    int               nu_gap;
    int               i;
    bit               found;
    r.status      = ST_OK;
    r.best_index  = '0;
    r.best_stress = '0;
    found         = 1'b0;
    case (fn)
      FN_CLEAR: begin
        held_count = 0;
      end
      FN_APPEND: begin
        if (held_count >= TFMS_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_entries[held_count].e      = e;
          held_entries[held_count].nu     = nu;
          held_entries[held_count].stress = st;
          r.best_index = held_count[9:0];
          held_count++;
        end
      end
      FN_QUERY: begin
        // A zero target cannot define a relative error, so no scan takes place.
        if (e != '0) begin
          tol64     = 64'(e_tol_model);
          tgt64     = 64'(e);
          limit     = tol64 * tgt64;
          target_nu = nu;
          for (i = 0; i < held_count; i++) begin
            e_gap    = (held_entries[i].e >= e) ? 64'(held_entries[i].e - e)
                                                : 64'(e - held_entries[i].e);
            entry_nu = held_entries[i].nu;
            nu_gap   = int'(entry_nu) - int'(target_nu);
            if (nu_gap < 0) nu_gap = -nu_gap;
            if ((e_gap << 16) <= limit && nu_gap <= int'(nu_tol_model)) begin
              if (!found || held_entries[i].stress < r.best_stress) begin
                found         = 1'b1;
                r.best_index  = i[9:0];
                r.best_stress = held_entries[i].stress;
              end
            end
          end
        end
        if (!found) r.status = ST_NONE;
      end
      default: ;
    endcase
    r.entry_count = held_count[10:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Request driver. Draws an idle gap, offers the request and holds it until accepted, then
  // records the predicted result. Valid is left high on return: the caller either sends the
  // next request in the same time step or lowers valid through drain_results.
  // ---------------------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] fn, input logic [31:0] e,
                              input logic [15:0] nu, input logic [31:0] st);
    int gap;
    search_result_t r;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= fn;
    value_e  <= e;
    value_nu <= nu;
    stress   <= st;
    do @(posedge clk); while (!in_ready);
    r = search_outcome(fn, e, nu, st);
    awaited_results = {awaited_results, r};
    case (fn)
      FN_CLEAR:  n_clear++;
      FN_APPEND: n_append++;
      FN_QUERY:  n_query++;
      default:   n_unused++;
    endcase
    if (fn == FN_QUERY && r.status == ST_OK) n_hits++;
    if (fn == FN_QUERY && r.status == ST_NONE) n_misses++;
    if (r.status == ST_FULL) n_full++;
  endtask

  // Stops offering requests and waits until every predicted result has been collected.
  // Every request of any code produces a result, so nothing is left running afterwards.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_register(input logic idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_E_TOL) e_tol_model = data;
    else nu_tol_model = data[14:0];
  endtask

  // Stimulus helpers: values scattered around a base so that roughly four in five fall
  // inside the current tolerance and the rest just outside it.
  function automatic logic [31:0] near_e(logic [31:0] base);
    longint unsigned tol64, base64, span, offset;
    tol64  = 64'(e_tol_model);
    base64 = 64'(base);
    span   = (tol64 * base64) >> 16;
    span   = span + span / 4 + 2;
    offset = {$urandom, $urandom} % (span + 1);
    return ($urandom_range(0, 1) != 0) ? base + offset[31:0] : base - offset[31:0];
  endfunction

  function automatic logic [15:0] near_nu(logic [15:0] base);
    int span, offset;
    span   = int'(nu_tol_model) + int'(nu_tol_model) / 4 + 2;
    offset = $urandom_range(0, span);
    return ($urandom_range(0, 1) != 0) ? base + offset[15:0] : base - offset[15:0];
  endfunction

  function automatic logic [31:0] pick_base_e();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(1, 255);
      default: return $urandom_range(32'h0000_8000, 32'h0100_0000);
    endcase
  endfunction

  // Half of the stresses come from a tiny range so that equal stresses are common.
  function automatic logic [31:0] pick_stress();
    return ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 7)) : $urandom;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result collector. Each side of the block idles at random; when asked, the collector
  // instead holds off for a long stretch so that the block fills and refuses requests.
  // ---------------------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = $urandom_range(0, max_gap);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      // Past the cap a broken design would only flood the log; mismatches are still counted.
      if (errors <= REPORT_CAP) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Every accepted result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    search_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $error("result with no request outstanding: status %0d index %0d count %0d",
               status, best_index, entry_count);
      end else begin
        want = awaited_results.pop_front();
        n_checked++;
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("best_index", 32'(want.best_index), 32'(best_index));
        compare_field("best_stress", want.best_stress, best_stress);
        compare_field("entry_count", 32'(want.entry_count), 32'(entry_count));
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Default tolerances straight after reset, probed exactly at and just past both limits,
  // with an equal-stress tie, a zero target, an empty table and the unused code.
  task automatic test_reset_defaults();
    send_request(FN_QUERY, UNIT_E, 16'd0, $urandom);
    send_request(FN_UNUSED, $urandom, 16'($urandom), $urandom);
    send_request(FN_CLEAR, $urandom, 16'($urandom), $urandom);
    send_request(FN_APPEND, UNIT_E + 32'd13107, 16'sd819, 32'd500);
    send_request(FN_APPEND, UNIT_E - 32'd13107, -16'sd819, 32'd300);
    send_request(FN_APPEND, UNIT_E + 32'd13108, 16'd0, 32'd1);
    send_request(FN_APPEND, UNIT_E, 16'sd820, 32'd2);
    send_request(FN_APPEND, UNIT_E, 16'd0, 32'd300);
    send_request(FN_QUERY, UNIT_E, 16'd0, $urandom);
    send_request(FN_QUERY, 32'd0, 16'd0, $urandom);
    send_request(FN_QUERY, UNIT_E, 16'h4000, $urandom);
    send_request(FN_UNUSED, $urandom, 16'($urandom), $urandom);
    drain_results();
  endtask

  // Field extremes under the widest and then the narrowest tolerances. The ratio tolerance
  // is written with the top data bit set, which the register must drop.
  task automatic test_field_extremes();
    write_register(CFG_E_TOL, 16'hFFFF);
    write_register(CFG_NU_TOL, 16'hFFFF);
    send_request(FN_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(FN_APPEND, 32'hFFFF_FFFF, 16'h8000, 32'hFFFF_FFFF);
    send_request(FN_APPEND, 32'd0, 16'h7FFF, 32'd0);
    send_request(FN_APPEND, 32'd1, 16'd0, 32'd0);
    send_request(FN_QUERY, 32'hFFFF_FFFF, 16'h8000, 32'd0);
    send_request(FN_QUERY, 32'd1, 16'd0, 32'hFFFF_FFFF);
    send_request(FN_QUERY, 32'd2, 16'h7FFF, 32'd0);
    send_request(FN_QUERY, 32'd0, 16'h7FFF, 32'd0);
    drain_results();
    write_register(CFG_E_TOL, 16'd0);
    write_register(CFG_NU_TOL, 16'd0);
    send_request(FN_QUERY, 32'hFFFF_FFFF, 16'h8000, 32'd0);
    send_request(FN_QUERY, 32'd2, 16'd0, 32'd0);
    drain_results();
    write_register(CFG_E_TOL, E_TOL_RESET);
    write_register(CFG_NU_TOL, {1'b0, NU_TOL_RESET});
  endtask

  // Builds a long table and scans it from end to end. The last slot holds the only zero
  // stress, so the winner sits at the highest index.
  task automatic test_long_table();
    int i;
    send_request(FN_CLEAR, $urandom, 16'($urandom), $urandom);
    for (i = 0; i < LONG_TABLE; i++) begin
      if (i == LONG_TABLE - 1) begin
        send_request(FN_APPEND, UNIT_E, 16'd0, 32'd0);
      end else begin
        send_request(FN_APPEND, UNIT_E + $urandom_range(0, 255),
                     16'($urandom_range(0, 63)), $urandom_range(1, 32'h7FFF_FFFF));
      end
    end
    send_request(FN_QUERY, UNIT_E, 16'd0, $urandom);
    send_request(FN_QUERY, UNIT_E, 16'h4000, $urandom);
    send_request(FN_UNUSED, $urandom, 16'($urandom), $urandom);
    send_request(FN_CLEAR, $urandom, 16'($urandom), $urandom);
    drain_results();
  endtask

  // The collector stops taking results for a long while; the requests behind the first
  // one back up until the block refuses new ones.
  task automatic test_receiver_hold();
    logic [31:0] base_e;
    logic [15:0] base_nu;
    int i;
    base_e    = pick_base_e();
    base_nu   = 16'($urandom);
    hold_sink = 1'b1;
    send_request(FN_CLEAR, $urandom, 16'($urandom), $urandom);
    for (i = 0; i < 8; i++) begin
      send_request(FN_APPEND, near_e(base_e), near_nu(base_nu), pick_stress());
    end
    send_request(FN_QUERY, near_e(base_e), near_nu(base_nu), $urandom);
    send_request(FN_QUERY, near_e(base_e), near_nu(base_nu), $urandom);
    drain_results();
  endtask

  // Tolerance settings cycle through both extremes, the defaults and random values.
  task automatic retune_tolerances(input int step);
    drain_results();
    case (step % 5)
      0: begin
        write_register(CFG_E_TOL, 16'hFFFF);
        write_register(CFG_NU_TOL, 16'h7FFF);
      end
      1: begin
        write_register(CFG_E_TOL, 16'd0);
        write_register(CFG_NU_TOL, 16'h8000);
      end
      2: begin
        write_register(CFG_E_TOL, E_TOL_RESET);
        write_register(CFG_NU_TOL, {1'b0, NU_TOL_RESET});
      end
      default: begin
        write_register(CFG_E_TOL, 16'($urandom_range(0, 20000)));
        write_register(CFG_NU_TOL, {1'($urandom_range(0, 1)), 15'($urandom_range(0, 4000))});
      end
    endcase
  endtask

  // Mostly well-formed sequences (clear, a run of appends around one material, queries
  // near it) with random content, mixed with bursts of raw noise and broken sequences.
  task automatic test_random_sequences(input int quota);
    int first, seq, kind, n, k;
    logic [31:0] base_e;
    logic [15:0] base_nu;
    first = n_clear + n_append + n_query;
    seq   = 0;
    while (n_clear + n_append + n_query - first < quota) begin
      if (seq % 6 == 0) retune_tolerances(seq / 6);
      // A few sequences in every twenty run with neither side idling.
      max_gap = (seq % 20 >= 17) ? 0 : 13;
      kind    = $urandom_range(0, 9);
      base_e  = pick_base_e();
      base_nu = 16'($urandom);
      if (kind == 0) begin
        n = $urandom_range(3, 10);
        repeat (n) send_request(2'($urandom_range(0, 3)), $urandom, 16'($urandom), $urandom);
      end else if (kind == 1) begin
        send_request(FN_QUERY, 32'd0, base_nu, $urandom);
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          send_request(FN_APPEND, near_e(base_e), near_nu(base_nu), pick_stress());
          if ($urandom_range(0, 2) == 0) begin
            send_request(FN_UNUSED, $urandom, 16'($urandom), $urandom);
          end
        end
        send_request(FN_QUERY, $urandom, 16'($urandom), $urandom);
        send_request(FN_QUERY, near_e(base_e), near_nu(base_nu), $urandom);
      end else begin
        if ($urandom_range(0, 5) != 0) send_request(FN_CLEAR, $urandom, 16'($urandom), $urandom);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
          send_request(FN_APPEND, near_e(base_e), near_nu(base_nu), pick_stress());
        end
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) begin
          send_request(FN_QUERY, near_e(base_e), near_nu(base_nu), $urandom);
        end
      end
      seq++;
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence. Reset is held once at the start; everything after runs on handshakes.
  // ---------------------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_field_extremes();
    test_long_table();
    test_receiver_hold();
    test_random_sequences(220);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d clears, %0d appends, %0d queries, %0d unused codes.",
             n_clear, n_append, n_query, n_unused);
    $display("Results checked: %0d; queries with a match %0d, without %0d; refused %0d.",
             n_checked, n_hits, n_misses, n_full);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
